FILE: sv/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants for the positional sequence store.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  // wide enough for both a position and the length, plus one for length+1
  localparam int unsigned CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DELETE   = 2'd1,
    CMD_RETRIEVE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // what a cell does with its word this cycle
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LEFT  = 2'd2,
    CELL_FROM_RIGHT = 2'd3
  } cell_op_e;

endpackage

FILE: sv/pss_cell.sv
// ----------------------------------------------------------------------------
// pss_cell
// One storage cell of the sequence; takes a new word or a neighbor's word.
// ----------------------------------------------------------------------------
module pss_cell (
  input  logic              clk_i,
  input  pss_pkg::cell_op_e op_i,
  input  pss_pkg::word_t    new_word_i,
  input  pss_pkg::word_t    left_word_i,
  input  pss_pkg::word_t    right_word_i,
  output pss_pkg::word_t    word_o
);
  import pss_pkg::*;

  word_t word_q;
  word_t word_d;

  always_comb begin
    case (op_i)
      CELL_LOAD:       word_d = new_word_i;
      CELL_FROM_LEFT:  word_d = left_word_i;
      CELL_FROM_RIGHT: word_d = right_word_i;
      default:         word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

FILE: sv/positional_sequence_store.sv
// result: an accepted command's result is registered in the output register
// throughput: one command per cycle unless the output stalls; every cell
//   shifts in the same cycle, so insert or delete cost the same as retrieve
// reset: the length clears to zero and the output register empties; stored
//   words are not cleared
// ----------------------------------------------------------------------------
// positional_sequence_store
// Bounded ordered list with insert, delete and retrieve by 1-based position,
// built as a row of cells that shift toward or away from the insert point.
// ----------------------------------------------------------------------------
module positional_sequence_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [6:0]  position_i,
  input  logic [31:0] item_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_value_o,
  output logic [1:0]  status_o,
  output logic [6:0]  length_o
);
  import pss_pkg::*;

  count_t   count_q, count_d;
  logic     out_valid_q;
  word_t    read_value_q, read_value_d;
  status_e  status_q, status_d;
  count_t   length_q;

  word_t    words   [DEPTH];
  cell_op_e cell_op [DEPTH];
  word_t    new_word;
  word_t    sel_word;

  logic             accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  count_t           pos_idx;
  logic             pos_zero;
  logic             ins_range_ok;
  logic             rd_range_ok;
  logic             do_insert;
  logic             do_delete;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign new_word   = DATA_WIDTH'(item_value_i);

  assign pos_ext      = CMP_W'(position_i);
  assign cnt_ext      = CMP_W'(count_q);
  assign pos_zero     = (position_i == '0);
  assign pos_idx      = CNT_W'(position_i) - CNT_W'(1);
  assign ins_range_ok = !pos_zero && (pos_ext <= cnt_ext + CMP_W'(1));
  assign rd_range_ok  = !pos_zero && (pos_ext <= cnt_ext);

  // word at the addressed position, one-hot and-or over the cells
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_idx == CNT_W'(i)) begin
        sel_word = sel_word | words[i];
      end
    end
  end

  always_comb begin
    status_d     = ST_OK;
    read_value_d = '0;
    do_insert    = 1'b0;
    do_delete    = 1'b0;
    count_d      = count_q;
    case (command_i)
      CMD_INSERT: begin
        if (!ins_range_ok) begin
          status_d = ST_RANGE;
        end else if (count_q == CNT_W'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          do_insert = 1'b1;
          count_d   = count_q + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (!rd_range_ok) begin
          status_d = ST_RANGE;
        end else begin
          do_delete = 1'b1;
          count_d   = count_q - CNT_W'(1);
        end
      end
      CMD_RETRIEVE: begin
        if (!rd_range_ok) begin
          status_d = ST_RANGE;
        end else begin
          read_value_d = sel_word;
        end
      end
      default: ;
    endcase
  end

  // per-cell shift control
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (accept && do_insert) begin
        if (CNT_W'(i) == pos_idx) begin
          cell_op[i] = CELL_LOAD;
        end else if (CNT_W'(i) > pos_idx && CNT_W'(i) <= count_q) begin
          cell_op[i] = CELL_FROM_LEFT;
        end
      end else if (accept && do_delete) begin
        if (CNT_W'(i) >= pos_idx && CMP_W'(i) + CMP_W'(1) < cnt_ext) begin
          cell_op[i] = CELL_FROM_RIGHT;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_word;
    word_t right_word;
    if (g == 0) begin : g_first
      assign left_word = new_word;
    end else begin : g_mid_l
      assign left_word = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_word = words[g];
    end else begin : g_mid_r
      assign right_word = words[g+1];
    end
    pss_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op[g]),
      .new_word_i  (new_word),
      .left_word_i (left_word),
      .right_word_i(right_word),
      .word_o      (words[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= read_value_d;
      status_q     <= status_d;
      length_q     <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = 32'(read_value_q);
  assign status_o     = status_q;
  assign length_o     = 7'(length_q);

endmodule
